>>> hdl/vglc_pkg.sv
// Package for the voxel grid label and count block.
// Holds register indexes, reset values, widths and the axis index function.
// No dependencies.
`default_nettype none

package vglc_pkg;

  localparam int MaxCellsDefault = 4096;

  localparam int CountW = 32;
  localparam int CoordW = 32;
  localparam int CellsW = 13;
  localparam int LabelW = 12;
  localparam int CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInvCellX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInvCellY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInvCellZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCellsX   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCellsY   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCellsZ   = 3'd5;

  localparam logic [CoordW-1:0] InvCellReset = 32'd65536;
  localparam logic [CellsW-1:0] CellsReset   = 13'd10;

  // operation codes
  localparam logic OpBin  = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic              ok;
    logic [CellsW-1:0] idx;
  } axis_t;

  // Clamp an index equal to the cell count to the last cell; reject larger ones and all when the count is zero.
  function automatic axis_t axis_index(input logic [CoordW-1:0] v,
                                       input logic [CellsW-1:0] cells);
    axis_t r;
    logic [CoordW-1:0] cells_ext;
    cells_ext = {{(CoordW-CellsW){1'b0}}, cells};
    r.ok  = (cells != '0) && (v <= cells_ext);
    r.idx = (v == cells_ext) ? (cells - 13'd1) : v[CellsW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/voxel_grid_label_and_count.sv
// Voxel grid binning with a saturating per-cell count store.
// Bin beat: one point at a time, the next accepted only once the result is handed over;
//   one shared 32x32 multiplier used six times, then a read-modify-write if in range.
// Read beat: one memory read per item in range, none when out of range.
// Reset: configuration and control registers take their defaults, then a clearing pass
//   writes zero to every count, one entry per cycle; no input is taken meanwhile.
`default_nettype none

module voxel_grid_label_and_count #(
  parameter int MAX_CELLS = vglc_pkg::MaxCellsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [vglc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [vglc_pkg::CoordW-1:0]  cfg_wdata_i,
  // input channel
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         operation_i,
  input  wire logic [vglc_pkg::CoordW-1:0]  x_offset_i,
  input  wire logic [vglc_pkg::CoordW-1:0]  y_offset_i,
  input  wire logic [vglc_pkg::CoordW-1:0]  z_offset_i,
  input  wire logic [vglc_pkg::LabelW-1:0]  cell_index_i,
  // result channel
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [vglc_pkg::LabelW-1:0]  label_o,
  output      logic [vglc_pkg::CountW-1:0]  cell_count_o,
  output      logic                         out_of_range_o
);

  localparam int AddrW = $clog2(MAX_CELLS);
  localparam int SumW  = 40;
  localparam int IdxExtW = 17;
  localparam logic [AddrW-1:0]   LastAddr   = AddrW'(MAX_CELLS - 1);
  localparam logic [SumW-1:0]    MaxCellsS  = SumW'(MAX_CELLS);
  localparam logic [IdxExtW-1:0] MaxCellsI  = IdxExtW'(MAX_CELLS);
  localparam logic [vglc_pkg::CountW-1:0] CountMax = '1;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MX    = 4'd2;
  localparam logic [3:0] S_MY    = 4'd3;
  localparam logic [3:0] S_MZ    = 4'd4;
  localparam logic [3:0] S_MC    = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_LBL   = 4'd8;
  localparam logic [3:0] S_RADDR = 4'd9;
  localparam logic [3:0] S_RDATA = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;

  // configuration
  logic [vglc_pkg::CoordW-1:0] inv_x_q, inv_y_q, inv_z_q;
  logic [vglc_pkg::CellsW-1:0] cells_x_q, cells_y_q, cells_z_q;

  // captured beat
  logic                         op_q;
  logic [vglc_pkg::CoordW-1:0]  x_q, y_q, z_q;

  // datapath
  logic [vglc_pkg::CoordW-1:0]   mul_a, mul_b;
  logic [2*vglc_pkg::CoordW-1:0] prod_q;
  vglc_pkg::axis_t               ax;
  logic                          ok_q;
  logic [vglc_pkg::CellsW-1:0]   xi_q, yi_q, zi_q;
  logic [25:0]                   cxy_q;
  logic [26:0]                   term_q;
  logic [SumW-1:0]               sum;
  logic [IdxExtW-1:0]            ci_ext;

  logic [AddrW-1:0]              addr_q;
  logic [vglc_pkg::LabelW-1:0]   lbl_q;
  logic [vglc_pkg::CountW-1:0]   cnt_q;
  logic                          bad_q;
  logic [AddrW-1:0]              clr_cnt_q;

  // memory port
  logic                          mem_we;
  logic [AddrW-1:0]              mem_waddr;
  logic [vglc_pkg::CountW-1:0]   mem_wdata;
  logic                          mem_re;
  logic [vglc_pkg::CountW-1:0]   mem_rdata;
  logic [vglc_pkg::CountW-1:0]   cnt_inc;

  // output register
  logic                          out_valid_q;
  logic [vglc_pkg::LabelW-1:0]   out_label_q;
  logic [vglc_pkg::CountW-1:0]   out_count_q;
  logic                          out_oor_q;

  logic in_fire;
  logic out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign ci_ext     = {{(IdxExtW-vglc_pkg::LabelW){1'b0}}, cell_index_i};

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q   <= vglc_pkg::InvCellReset;
      inv_y_q   <= vglc_pkg::InvCellReset;
      inv_z_q   <= vglc_pkg::InvCellReset;
      cells_x_q <= vglc_pkg::CellsReset;
      cells_y_q <= vglc_pkg::CellsReset;
      cells_z_q <= vglc_pkg::CellsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vglc_pkg::RegInvCellX: inv_x_q   <= cfg_wdata_i;
        vglc_pkg::RegInvCellY: inv_y_q   <= cfg_wdata_i;
        vglc_pkg::RegInvCellZ: inv_z_q   <= cfg_wdata_i;
        vglc_pkg::RegCellsX:   cells_x_q <= cfg_wdata_i[vglc_pkg::CellsW-1:0];
        vglc_pkg::RegCellsY:   cells_y_q <= cfg_wdata_i[vglc_pkg::CellsW-1:0];
        vglc_pkg::RegCellsZ:   cells_z_q <= cfg_wdata_i[vglc_pkg::CellsW-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier: three axis products, then the label terms.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MX: begin
        mul_a = x_q;
        mul_b = inv_x_q;
      end
      S_MY: begin
        mul_a = y_q;
        mul_b = inv_y_q;
      end
      S_MZ: begin
        mul_a = z_q;
        mul_b = inv_z_q;
      end
      S_MC: begin
        mul_a = {19'd0, cells_x_q};
        mul_b = {19'd0, cells_y_q};
      end
      S_M1: begin
        mul_a = {19'd0, yi_q};
        mul_b = {19'd0, cells_x_q};
      end
      S_M2: begin
        mul_a = {19'd0, zi_q};
        mul_b = {6'd0, cxy_q};
      end
      default: ;
    endcase
  end

  // Check the axis product registered in the previous step.
  always_comb begin
    case (state_q)
      S_MY:    ax = vglc_pkg::axis_index(prod_q[63:32], cells_x_q);
      S_MZ:    ax = vglc_pkg::axis_index(prod_q[63:32], cells_y_q);
      default: ax = vglc_pkg::axis_index(prod_q[63:32], cells_z_q);
    endcase
  end

  assign sum     = prod_q[SumW-1:0] + {{(SumW-27){1'b0}}, term_q};
  assign cnt_inc = (mem_rdata == CountMax) ? mem_rdata : (mem_rdata + 32'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_cnt_q == LastAddr) state_d = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (operation_i == vglc_pkg::OpBin) begin
            state_d = S_MX;
          end else if (ci_ext >= MaxCellsI) begin
            state_d = S_FIN;
          end else begin
            state_d = S_RADDR;
          end
        end
      end
      S_MX:    state_d = S_MY;
      S_MY:    state_d = S_MZ;
      S_MZ:    state_d = S_MC;
      S_MC:    state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_LBL;
      S_LBL:   state_d = (!ok_q || sum >= MaxCellsS) ? S_FIN : S_RADDR;
      S_RADDR: state_d = S_RDATA;
      S_RDATA: state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state: sequencer, clearing sweep, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // hold the beat; a read resolves its range check here
          op_q   <= operation_i;
          x_q    <= x_offset_i;
          y_q    <= y_offset_i;
          z_q    <= z_offset_i;
          addr_q <= ci_ext[AddrW-1:0];
          lbl_q  <= cell_index_i;
          cnt_q  <= '0;
          bad_q  <= (ci_ext >= MaxCellsI);
        end
      end
      S_MX: prod_q <= mul_a * mul_b;
      S_MY: begin
        prod_q <= mul_a * mul_b;
        xi_q   <= ax.idx;
        ok_q   <= ax.ok;
      end
      S_MZ: begin
        prod_q <= mul_a * mul_b;
        yi_q   <= ax.idx;
        ok_q   <= ok_q && ax.ok;
      end
      S_MC: begin
        prod_q <= mul_a * mul_b;
        zi_q   <= ax.idx;
        ok_q   <= ok_q && ax.ok;
      end
      S_M1: begin
        prod_q <= mul_a * mul_b;
        cxy_q  <= prod_q[25:0];
      end
      S_M2: begin
        prod_q <= mul_a * mul_b;
        term_q <= {1'b0, prod_q[25:0]} + {14'd0, xi_q};
      end
      S_LBL: begin
        // a rejected point reports label and count as zero
        if (!ok_q || sum >= MaxCellsS) begin
          bad_q <= 1'b1;
          lbl_q <= '0;
          cnt_q <= '0;
        end else begin
          bad_q <= 1'b0;
          lbl_q <= sum[vglc_pkg::LabelW-1:0];
        end
        addr_q <= sum[AddrW-1:0];
      end
      S_RDATA: cnt_q <= (op_q == vglc_pkg::OpBin) ? cnt_inc : mem_rdata;
      default: ;
    endcase
  end

  // Output payload loads once the register is free.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      out_label_q <= lbl_q;
      out_count_q <= cnt_q;
      out_oor_q   <= bad_q;
    end
  end

  // Memory access: clearing sweep or write-back of the incremented count.
  // Items run one at a time, so the write-back lands before the next read.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = cnt_inc;
    if (state_q == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (state_q == S_RDATA && op_q == vglc_pkg::OpBin) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = (state_q == S_RADDR);

  vglc_count_ram #(
    .Depth (MAX_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign label_o        = out_label_q;
  assign cell_count_o   = out_count_q;
  assign out_of_range_o = out_oor_q;

  // A rejected beat never carries a count.
  ap_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (cell_count_o == '0))
    else $error("out-of-range result with nonzero count");

  // Read data is used only in the cycle after the read was issued.
  ap_rd_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDATA) |-> ($past(state_q) == S_RADDR))
    else $error("count used without a preceding read");

  // The clearing sweep ends at the last entry and hands over to idle.
  ap_clr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && clr_cnt_q == LastAddr) |=> (state_q == S_IDLE))
    else $error("clearing sweep did not finish");

  // A bin beat that counted leaves a count of at least one.
  ap_bin_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDATA && op_q == vglc_pkg::OpBin) |=> (cnt_q != '0))
    else $error("counted cell reports zero");

endmodule

`default_nettype wire

>>> hdl/vglc_count_ram.sv
// Per-cell count store: one write port and one read port, registered read.
// Depends on vglc_pkg for the count width.
`default_nettype none

module vglc_count_ram #(
  parameter int Depth = vglc_pkg::MaxCellsDefault,
  localparam int AW = $clog2(Depth)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [vglc_pkg::CountW-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output      logic [vglc_pkg::CountW-1:0] rdata_o
);

  logic [vglc_pkg::CountW-1:0] mem [Depth];
  logic [vglc_pkg::CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
